// ===== rtl/core/dtte_pkg.sv =====
// Package for the date/time text parser: phase codes, layout codes, queue record
// and the month tables used by the back end. No dependencies.
`timescale 1ns / 1ps
package dtte_pkg;

  typedef enum logic [3:0] {
    PH_LEAD      = 4'd0,
    PH_DATE      = 4'd1,
    PH_SEP       = 4'd2,
    PH_HOUR      = 4'd3,
    PH_COLON     = 4'd4,
    PH_MIN       = 4'd5,
    PH_AFTER_MIN = 4'd6,
    PH_SEC       = 4'd7,
    PH_AFTER_SEC = 4'd8,
    PH_FRAC      = 4'd9,
    PH_ZONE      = 4'd10,
    PH_TRAIL     = 4'd11
  } phase_t;

  localparam logic [2:0] LAY_NONE      = 3'd0;
  localparam logic [2:0] LAY_ISO_DASH  = 3'd1;
  localparam logic [2:0] LAY_ISO_SLASH = 3'd2;
  localparam logic [2:0] LAY_DMY_DOT   = 3'd3;
  localparam logic [2:0] LAY_DMY_SLASH = 3'd4;
  localparam logic [2:0] LAY_MDY_SLASH = 3'd5;

  localparam int DateLen   = 10;
  localparam int EpochW    = 39;
  localparam int DaysW     = 24;
  localparam int OffsW     = 20;
  localparam int QueueDepth = 2;

  // One finished field, handed from the front to the back end.
  typedef struct packed {
    logic                  ok;
    logic [DateLen-1:0][7:0] date;
    logic [2:0][6:0]       tf;
    logic [1:0][6:0]       zf;
    logic                  zsign;
  } rec_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic is_dig(input logic [7:0] c);
    return (c >= 8'd48) && (c <= 8'd57);
  endfunction

  // Days in a month, February as a common year.
  function automatic logic [4:0] month_len(input logic [3:0] m);
    case (m)
      4'd2:                      return 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   return 5'd30;
      default:                   return 5'd31;
    endcase
  endfunction

  // Day of year with the year starting on March 1.
  function automatic logic [8:0] month_start(input logic [3:0] m);
    case (m)
      4'd3:    return 9'd0;
      4'd4:    return 9'd31;
      4'd5:    return 9'd61;
      4'd6:    return 9'd92;
      4'd7:    return 9'd122;
      4'd8:    return 9'd153;
      4'd9:    return 9'd184;
      4'd10:   return 9'd214;
      4'd11:   return 9'd245;
      4'd12:   return 9'd275;
      4'd1:    return 9'd306;
      4'd2:    return 9'd337;
      default: return 9'd0;
    endcase
  endfunction

endpackage

// ===== rtl/core/datetime_text_to_epoch_seconds.sv =====
// Top level of the date/time text parser: front parser, record queue, back pipeline.
// Depends on dtte_pkg, dtte_front, dtte_queue, dtte_back.
//
//   channel | handshake           | payload
//   in      | in_valid / in_stall | char_code[7:0], is_last
//   out     | out_valid/out_stall | parse_ok, epoch_seconds[38:0], date_layout[2:0]
//
// One byte beat per cycle while in_stall is low. The record of the beat carrying
// is_last lands in the queue at the edge that takes that beat, then passes through
// the four back stages and the output register before the result is presented.
// rst is synchronous; it clears parser state, queue pointers and stage valids.
// A stall on the output freezes the back pipeline; the two-entry queue keeps
// taking fields, and in_stall rises only while the queue is full.
`timescale 1ns / 1ps
module datetime_text_to_epoch_seconds import dtte_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               char_code,
  input  logic                     is_last,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic                     parse_ok,
  output logic signed [EpochW-1:0] epoch_seconds,
  output logic [2:0]               date_layout
);

  logic acc;
  logic push, pop, q_empty, q_full, en;
  rec_t rec_in, rec_out;

  // Take a beat whenever the queue has room.
  assign in_stall = q_full;
  assign acc      = in_valid && !in_stall;

  // Advance the back pipeline unless a finished result is held.
  assign en  = !(out_valid && out_stall);
  assign pop = en && !q_empty;

  dtte_front u_front (
    .clk  (clk),
    .rst  (rst),
    .acc  (acc),
    .c    (char_code),
    .last (is_last),
    .push (push),
    .rec  (rec_in)
  );

  dtte_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (rec_in),
    .pop   (pop),
    .empty (q_empty),
    .full  (q_full),
    .rdata (rec_out)
  );

  dtte_back u_back (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (pop),
    .rec      (rec_out),
    .v_out    (out_valid),
    .ok_out   (parse_ok),
    .secs_out (epoch_seconds),
    .lay_out  (date_layout)
  );

endmodule

// ===== rtl/core/dtte_front.sv =====
// Front end: per-byte parser state machine; pushes one record per field.
// Depends on dtte_pkg.
`timescale 1ns / 1ps
module dtte_front import dtte_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       acc,
  input  logic [7:0] c,
  input  logic       last,
  output logic       push,
  output rec_t       rec
);

  phase_t                  phase, phase_next;
  logic [3:0]              pos, pos_next;
  logic [DateLen-1:0][7:0] date, date_next;
  logic [2:0][6:0]         tf, tf_next;
  logic [1:0][6:0]         zf, zf_next;
  logic                    zsign, zsign_next;
  logic                    pend, pend_next;
  logic                    err, err_next;

  logic       fail, do_dig, do_tail;
  logic [1:0] dig_idx;
  logic       dig_first;
  phase_t     dig_cur, dig_to;
  logic [3:0] dval;

  assign dval = 4'(c - 8'd48);

  always_comb begin
    phase_next = phase;
    pos_next   = pos;
    date_next  = date;
    tf_next    = tf;
    zf_next    = zf;
    zsign_next = zsign;
    pend_next  = pend;
    err_next   = err;
    fail       = 1'b0;
    do_dig     = 1'b0;
    do_tail    = 1'b0;
    dig_idx    = 2'd0;
    dig_first  = (pos == 4'd0);
    dig_cur    = phase;
    dig_to     = PH_COLON;
    if (acc && !err) begin
      case (phase)
        PH_LEAD: begin
          if (!is_ws(c)) begin
            date_next[0] = c;
            pos_next     = 4'd1;
            phase_next   = PH_DATE;
          end
        end
        PH_DATE: begin
          if (is_ws(c) || pos >= 4'(DateLen)) begin
            fail = 1'b1;
          end else begin
            date_next[pos] = c;
            pos_next       = pos + 4'd1;
            if (pos == 4'(DateLen - 1)) begin
              pos_next   = 4'd0;
              phase_next = PH_SEP;
            end
          end
        end
        PH_SEP: begin
          if (pend) begin
            if (is_ws(c)) begin
              phase_next = PH_TRAIL;
            end else begin
              do_dig    = 1'b1;
              dig_first = 1'b1;
              dig_cur   = PH_HOUR;
            end
          end else if (c == "T" || c == "t") begin
            pos_next   = 4'd0;
            phase_next = PH_HOUR;
          end else if (c == " ") begin
            pend_next = 1'b1;
          end else if (is_ws(c)) begin
            phase_next = PH_TRAIL;
          end else begin
            fail = 1'b1;
          end
        end
        PH_HOUR: do_dig = 1'b1;
        PH_COLON: begin
          if (c == ":") begin
            pos_next   = 4'd0;
            phase_next = PH_MIN;
          end else begin
            fail = 1'b1;
          end
        end
        PH_MIN: begin
          do_dig  = 1'b1;
          dig_idx = 2'd1;
          dig_to  = PH_AFTER_MIN;
        end
        PH_AFTER_MIN: begin
          if (c == ":") begin
            pos_next   = 4'd0;
            phase_next = PH_SEC;
          end else begin
            do_tail = 1'b1;
          end
        end
        PH_SEC: begin
          do_dig  = 1'b1;
          dig_idx = 2'd2;
          dig_to  = PH_AFTER_SEC;
        end
        PH_AFTER_SEC: begin
          if (c == ".") phase_next = PH_FRAC;
          else do_tail = 1'b1;
        end
        PH_FRAC: begin
          if (!is_dig(c)) do_tail = 1'b1;
        end
        PH_ZONE: begin
          if (pos == 4'd2) begin
            if (c != ":") fail = 1'b1;
          end else if (!is_dig(c)) begin
            fail = 1'b1;
          end else if (pos < 4'd2) begin
            zf_next[0] = 7'(zf[0] * 7'd10 + 7'(dval));
          end else begin
            zf_next[1] = 7'(zf[1] * 7'd10 + 7'(dval));
          end
          pos_next = pos + 4'd1;
          if (pos >= 4'd4) phase_next = PH_TRAIL;
        end
        PH_TRAIL: begin
          if (!is_ws(c)) fail = 1'b1;
        end
        default: fail = 1'b1;
      endcase

      // Two-digit time field.
      if (do_dig) begin
        if (!is_dig(c)) begin
          fail = 1'b1;
        end else begin
          tf_next[dig_idx] = 7'(tf[dig_idx] * 7'd10 + 7'(dval));
          if (dig_first) begin
            pos_next   = 4'd1;
            phase_next = dig_cur;
          end else begin
            pos_next   = 4'd0;
            phase_next = dig_to;
          end
        end
      end

      // End of the time body: zone sign, Z, or whitespace.
      if (do_tail) begin
        if (c == "+" || c == "-") begin
          zsign_next = (c == "-");
          pos_next   = 4'd0;
          phase_next = PH_ZONE;
        end else if (c == "Z" || c == "z" || is_ws(c)) begin
          phase_next = PH_TRAIL;
        end else begin
          fail = 1'b1;
        end
      end

      if (fail) err_next = 1'b1;
    end
  end

  always_comb begin
    push      = acc && last;
    rec.ok    = !err_next && (phase_next == PH_SEP || phase_next == PH_AFTER_MIN ||
                phase_next == PH_AFTER_SEC || phase_next == PH_FRAC ||
                phase_next == PH_TRAIL);
    rec.date  = date_next;
    rec.tf    = tf_next;
    rec.zf    = zf_next;
    rec.zsign = zsign_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (acc && last)) begin
      phase <= PH_LEAD;
      pos   <= '0;
      tf    <= '0;
      zf    <= '0;
      zsign <= 1'b0;
      pend  <= 1'b0;
      err   <= 1'b0;
    end else if (acc) begin
      phase <= phase_next;
      pos   <= pos_next;
      tf    <= tf_next;
      zf    <= zf_next;
      zsign <= zsign_next;
      pend  <= pend_next;
      err   <= err_next;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) date <= date_next;
  end

endmodule

// ===== rtl/core/dtte_queue.sv =====
// Two-entry record queue between front and back end.
// Depends on dtte_pkg.
`timescale 1ns / 1ps
module dtte_queue import dtte_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rec_t wdata,
  input  logic pop,
  output logic empty,
  output logic full,
  output rec_t rdata
);

  rec_t       mem [QueueDepth];
  logic       wptr, rptr;
  logic [1:0] count;

  assign empty = (count == 2'd0);
  assign full  = (count == 2'(QueueDepth));
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop)  rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= wdata;
  end

endmodule

// ===== rtl/core/dtte_back.sv =====
// Back end: five-stage pipeline from a parsed record to validity, layout and
// epoch seconds. Depends on dtte_pkg.
`timescale 1ns / 1ps
module dtte_back import dtte_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_v,
  input  rec_t                     rec,
  output logic                     v_out,
  output logic                     ok_out,
  output logic signed [EpochW-1:0] secs_out,
  output logic [2:0]               lay_out
);

  // Stage 1: decode date digits.
  logic [3:0]  dv [DateLen];
  logic [DateLen-1:0] dg;
  logic        iso_ok, dmy_ok;
  logic [6:0]  a_v, b_v;
  logic [13:0] y_c, y_iso, y_dmy;
  logic [6:0]  m_c, d_c;
  logic [2:0]  lay_c;
  logic        ok1_c;

  always_comb begin
    for (int i = 0; i < DateLen; i++) begin
      dv[i] = 4'(rec.date[i] - 8'd48);
      dg[i] = is_dig(rec.date[i]);
    end
    y_iso = 14'(dv[0] * 10'd1000) + 14'(dv[1] * 7'd100) + 14'(dv[2] * 4'd10) + 14'(dv[3]);
    y_dmy = 14'(dv[6] * 10'd1000) + 14'(dv[7] * 7'd100) + 14'(dv[8] * 4'd10) + 14'(dv[9]);
    a_v   = 7'(dv[0] * 4'd10) + 7'(dv[1]);
    b_v   = 7'(dv[3] * 4'd10) + 7'(dv[4]);
    iso_ok = dg[0] && dg[1] && dg[2] && dg[3] && dg[5] && dg[6] && dg[8] && dg[9] &&
             rec.date[7] == rec.date[4];
    dmy_ok = dg[0] && dg[1] && dg[3] && dg[4] && dg[6] && dg[7] && dg[8] && dg[9] &&
             rec.date[5] == rec.date[2];
    y_c   = y_iso;
    m_c   = 7'(dv[5] * 4'd10) + 7'(dv[6]);
    d_c   = 7'(dv[8] * 4'd10) + 7'(dv[9]);
    lay_c = LAY_NONE;
    if (rec.date[4] == "-" || rec.date[4] == "/") begin
      if (iso_ok) lay_c = (rec.date[4] == "-") ? LAY_ISO_DASH : LAY_ISO_SLASH;
    end else if (rec.date[2] == "." || rec.date[2] == "/") begin
      y_c = y_dmy;
      d_c = a_v;
      m_c = b_v;
      if (dmy_ok) begin
        if (rec.date[2] == ".") begin
          lay_c = LAY_DMY_DOT;
        end else if (a_v <= 7'd12 && b_v > 7'd12) begin
          lay_c = LAY_MDY_SLASH;
          m_c   = a_v;
          d_c   = b_v;
        end else begin
          lay_c = LAY_DMY_SLASH;
        end
      end
    end
    ok1_c = rec.ok && lay_c != LAY_NONE && rec.tf[0] <= 7'd23 && rec.tf[1] <= 7'd59 &&
            rec.tf[2] <= 7'd60;
  end

  logic            s1_v, s1_ok, s1_zs;
  logic [13:0]     s1_y;
  logic [6:0]      s1_m, s1_d;
  logic [2:0]      s1_lay;
  logic [2:0][6:0] s1_tf;
  logic [1:0][6:0] s1_zf;

  // Stage 2: calendar check, quotients by 100, day of year, time parts.
  logic [13:0] yy_c;
  logic [13:0] qy_c, qyy_c;
  logic [6:0]  ry_c;
  logic        leap_c;
  logic [4:0]  lim_c;
  logic        ok2_c;
  logic [8:0]  doy_c;
  logic [16:0] tsec_c;
  logic [18:0] zoff_c;

  always_comb begin
    yy_c   = s1_y - 14'(s1_m <= 7'd2);
    // x / 100 as a reciprocal multiply, exact below 43699.
    qy_c   = 14'((27'(s1_y) * 27'd5243) >> 19);
    qyy_c  = 14'((27'(yy_c) * 27'd5243) >> 19);
    ry_c   = 7'(s1_y - 14'(qy_c * 7'd100));
    leap_c = (s1_y[1:0] == 2'd0 && ry_c != 7'd0) || (ry_c == 7'd0 && qy_c[1:0] == 2'd0);
    lim_c  = month_len(s1_m[3:0]);
    if (s1_m == 7'd2 && leap_c) lim_c = 5'd29;
    ok2_c  = s1_ok && s1_y >= 14'd1000 && s1_y <= 14'd9999 && s1_m >= 7'd1 &&
             s1_m <= 7'd12 && s1_d >= 7'd1 && s1_d <= 7'(lim_c);
    doy_c  = month_start(s1_m[3:0]) + 9'(s1_d) - 9'd1;
    tsec_c = 17'(s1_tf[0] * 12'd3600) + 17'(s1_tf[1] * 6'd60) + 17'(s1_tf[2]);
    zoff_c = 19'(s1_zf[0] * 12'd3600) + 19'(s1_zf[1] * 6'd60);
  end

  logic        s2_v, s2_ok, s2_zs;
  logic [13:0] s2_yy, s2_q;
  logic [8:0]  s2_doy;
  logic [16:0] s2_tsec;
  logic [18:0] s2_zoff;
  logic [2:0]  s2_lay;

  // Stage 3: day count and signed time-of-day with zone.
  logic signed [DaysW-1:0] days_c;
  logic signed [OffsW-1:0] tz_c;

  always_comb begin
    days_c = DaysW'(s2_yy * 9'd365) + DaysW'(s2_yy >> 2) - DaysW'(s2_q)
           + DaysW'(s2_q >> 2) + DaysW'(s2_doy) - DaysW'(719468);
    tz_c   = s2_zs ? OffsW'(s2_tsec) + OffsW'(s2_zoff) : OffsW'(s2_tsec) - OffsW'(s2_zoff);
  end

  logic                    s3_v, s3_ok;
  logic signed [DaysW-1:0] s3_days;
  logic signed [OffsW-1:0] s3_tz;
  logic [2:0]              s3_lay;

  // Stage 4: days times seconds per day.
  logic                     s4_v, s4_ok;
  logic signed [EpochW-1:0] s4_prod;
  logic signed [OffsW-1:0]  s4_tz;
  logic [2:0]               s4_lay;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v  <= 1'b0;
      s2_v  <= 1'b0;
      s3_v  <= 1'b0;
      s4_v  <= 1'b0;
      v_out <= 1'b0;
    end else if (en) begin
      s1_v  <= in_v;
      s2_v  <= s1_v;
      s3_v  <= s2_v;
      s4_v  <= s3_v;
      v_out <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_ok   <= ok1_c;
      s1_y    <= y_c;
      s1_m    <= m_c;
      s1_d    <= d_c;
      s1_lay  <= lay_c;
      s1_tf   <= rec.tf;
      s1_zf   <= rec.zf;
      s1_zs   <= rec.zsign;

      s2_ok   <= ok2_c;
      s2_yy   <= yy_c;
      s2_q    <= qyy_c;
      s2_doy  <= doy_c;
      s2_tsec <= tsec_c;
      s2_zoff <= zoff_c;
      s2_zs   <= s1_zs;
      s2_lay  <= s1_lay;

      s3_ok   <= s2_ok;
      s3_days <= days_c;
      s3_tz   <= tz_c;
      s3_lay  <= s2_lay;

      s4_ok   <= s3_ok;
      s4_prod <= EpochW'(s3_days * 39'sd86400);
      s4_tz   <= s3_tz;
      s4_lay  <= s3_lay;

      ok_out   <= s4_ok;
      secs_out <= s4_ok ? s4_prod + EpochW'(s4_tz) : '0;
      lay_out  <= s4_ok ? s4_lay : LAY_NONE;
    end
  end

endmodule

// ===== rtl/core/dtte_checker.sv =====
// Port-level checks for the date/time text parser, bound to the top level.
// Depends on dtte_pkg and datetime_text_to_epoch_seconds.
`timescale 1ns / 1ps
module dtte_checker import dtte_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic                     parse_ok,
  input logic signed [EpochW-1:0] epoch_seconds,
  input logic [2:0]               date_layout
);

  // Hold a stalled result beat.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(parse_ok) &&
      $stable(epoch_seconds) && $stable(date_layout))
    else $error("stalled result changed");

  // Drop value and layout on a bad field.
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !parse_ok |-> epoch_seconds == '0 && date_layout == LAY_NONE)
    else $error("invalid result carries data");

  a_good_layout: assert property (@(posedge clk) disable iff (rst)
    out_valid && parse_ok |-> date_layout != LAY_NONE && date_layout <= LAY_MDY_SLASH)
    else $error("valid result without layout");

  a_good_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && parse_ok |-> epoch_seconds >= -39'sd30610586340 &&
      epoch_seconds <= 39'sd253402663140)
    else $error("epoch out of range");

endmodule

bind datetime_text_to_epoch_seconds dtte_checker u_dtte_checker (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (out_valid),
  .out_stall     (out_stall),
  .parse_ok      (parse_ok),
  .epoch_seconds (epoch_seconds),
  .date_layout   (date_layout)
);
